/* src/ibs_pkg.sv */
package ibs_pkg;

  localparam int COORD_BITS_DEF = 32;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

/* src/ibs_engine.sv */
module ibs_engine #(
  parameter int COORD_BITS = ibs_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         kind,
  input  logic [COORD_BITS-1:0]        px,
  input  logic [COORD_BITS-1:0]        py,
  input  logic [COORD_BITS-1:0]        pz,
  input  logic                         out_free,
  output ibs_pkg::eng_stat_t           stat,
  output logic [COORD_BITS-1:0]        cx,
  output logic [COORD_BITS-1:0]        cy,
  output logic [COORD_BITS-1:0]        cz,
  output logic [COORD_BITS-1:0]        rad,
  output logic                         has_sphere,
  output logic                         grew
);

  localparam int W  = COORD_BITS;
  localparam int WW = 2 * W + 4;
  localparam int CW = $clog2(W + 3);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_ABS, S_SQ, S_SQRT, S_CMP, S_MUL, S_DIV, S_UPD, S_RAD, S_FIN
  } state_t;

  state_t         state;
  logic [1:0]     ax;
  logic [CW-1:0]  cnt;
  logic [W-1:0]   cen [3];
  logic [W-1:0]   pt [3];
  logic [W:0]     dmag [3];
  logic [2:0]     dneg;
  logic [WW-1:0]  acc;
  logic [WW-1:0]  res;
  logic [WW-1:0]  bitm;
  logic [WW-1:0]  mcand;
  logic [W:0]     mplier;
  logic [W:0]     dr;
  logic [W+1:0]   drem;
  logic [W:0]     dq;

  // shared add/subtract unit
  logic [WW-1:0]  op_a;
  logic [WW-1:0]  op_b;
  logic           op_sub;
  logic [WW:0]    sum_full;
  logic [WW-1:0]  sum;
  logic           co;
  logic [W+2:0]   rem2;
  logic [W:0]     dr_v;
  logic           last_mul;

  assign sum_full = {1'b0, op_a} + {1'b0, op_b ^ {WW{op_sub}}} + {{WW{1'b0}}, op_sub};
  assign sum      = sum_full[WW-1:0];
  assign co       = sum_full[WW];
  assign rem2     = {drem, dq[W]};
  assign dr_v     = sum[W+1:1];
  assign last_mul = (cnt == CW'(W));

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (state)
      S_DIFF: begin
        op_a   = {{(WW-W){pt[ax][W-1]}}, pt[ax]};
        op_b   = {{(WW-W){cen[ax][W-1]}}, cen[ax]};
        op_sub = 1'b1;
      end
      S_ABS: begin
        op_b   = {{(WW-W-1){1'b0}}, dmag[ax]};
        op_sub = 1'b1;
      end
      S_SQ, S_MUL: begin
        op_a = acc;
        op_b = mplier[0] ? mcand : '0;
      end
      S_SQRT: begin
        op_a   = acc;
        op_b   = res | bitm;
        op_sub = 1'b1;
      end
      S_CMP: begin
        op_a   = res;
        op_b   = {{(WW-W){1'b0}}, rad};
        op_sub = 1'b1;
      end
      S_DIV: begin
        op_a   = {{(WW-W-3){1'b0}}, rem2};
        op_b   = res;
        op_sub = 1'b1;
      end
      S_UPD: begin
        op_a   = {{(WW-W){cen[ax][W-1]}}, cen[ax]};
        op_b   = {{(WW-W-1){1'b0}}, dq};
        op_sub = dneg[ax];
      end
      S_RAD: begin
        op_a = {{(WW-W){1'b0}}, rad};
        op_b = {{(WW-W-1){1'b0}}, dr};
      end
      default: begin
        op_a   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ax         <= '0;
      cnt        <= '0;
      cen[0]     <= '0;
      cen[1]     <= '0;
      cen[2]     <= '0;
      rad        <= '0;
      has_sphere <= 1'b0;
      grew       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (kind) begin
              cen[0] <= '0;
              cen[1] <= '0;
              cen[2] <= '0;
              rad <= '0;
              has_sphere <= 1'b0;
              grew <= 1'b0;
              state <= S_FIN;
            end else if (!has_sphere) begin
              cen[0] <= px;
              cen[1] <= py;
              cen[2] <= pz;
              rad <= '0;
              has_sphere <= 1'b1;
              grew <= 1'b1;
              state <= S_FIN;
            end else begin
              pt[0] <= px;
              pt[1] <= py;
              pt[2] <= pz;
              ax <= '0;
              grew <= 1'b0;
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          dmag[ax] <= sum[W:0];
          dneg[ax] <= sum[W];
          state <= S_ABS;
        end
        S_ABS: begin
          if (dneg[ax]) dmag[ax] <= sum[W:0];
          if (ax == 2'd2) begin
            ax <= '0;
            acc <= '0;
            mcand <= {{(WW-W-1){1'b0}}, dmag[0]};
            mplier <= dmag[0];
            cnt <= '0;
            state <= S_SQ;
          end else begin
            ax <= ax + 2'd1;
            state <= S_DIFF;
          end
        end
        S_SQ: begin
          acc <= sum;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          cnt <= cnt + CW'(1);
          if (last_mul) begin
            cnt <= '0;
            if (ax == 2'd2) begin
              res <= '0;
              bitm <= WW'(1) << (2 * W + 2);
              state <= S_SQRT;
            end else begin
              ax <= ax + 2'd1;
              mcand <= {{(WW-W-1){1'b0}}, dmag[ax + 2'd1]};
              mplier <= dmag[ax + 2'd1];
            end
          end
        end
        S_SQRT: begin
          if (co) begin
            acc <= sum;
            res <= (res >> 1) | bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(W + 1)) state <= S_CMP;
        end
        S_CMP: begin
          if (co && (sum != '0) && (dr_v != '0)) begin
            dr <= dr_v;
            ax <= '0;
            acc <= '0;
            mcand <= {{(WW-W-1){1'b0}}, dmag[0]};
            mplier <= dr_v;
            cnt <= '0;
            state <= S_MUL;
          end else begin
            state <= S_FIN;
          end
        end
        S_MUL: begin
          acc <= sum;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          cnt <= cnt + CW'(1);
          if (last_mul) begin
            drem <= {1'b0, sum[2*W+1:W+1]};
            dq <= sum[W:0];
            cnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          drem <= co ? sum[W+1:0] : rem2[W+1:0];
          dq <= {dq[W-1:0], co};
          cnt <= cnt + CW'(1);
          if (last_mul) state <= S_UPD;
        end
        S_UPD: begin
          cen[ax] <= sum[W-1:0];
          if (ax == 2'd2) begin
            state <= S_RAD;
          end else begin
            ax <= ax + 2'd1;
            acc <= '0;
            mcand <= {{(WW-W-1){1'b0}}, dmag[ax + 2'd1]};
            mplier <= dr;
            cnt <= '0;
            state <= S_MUL;
          end
        end
        S_RAD: begin
          rad <= (sum[WW-1:W] != '0) ? {W{1'b1}} : sum[W-1:0];
          grew <= 1'b1;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_FIN) && out_free;
  assign cx = cen[0];
  assign cy = cen[1];
  assign cz = cen[2];

endmodule

/* src/incremental_bounding_sphere_unit.sv */
// Clear and first point go straight to the finish state; a later point that stays
// inside runs difference, absolute value, square, square root and compare steps, and
// one that grows the sphere adds multiply, divide, center update and radius steps.
// All steps share one add/subtract unit. One transaction in flight; the engine is
// idle again once the result is registered, so the next one is taken even while it waits.
// Reset (rst, synchronous) clears the sphere to invalid with zero center/radius.
module incremental_bounding_sphere_unit #(
  parameter int COORD_BITS = ibs_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_ready,
  input  logic                  kind,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  logic [COORD_BITS-1:0] pz,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [COORD_BITS-1:0] center_x,
  output logic [COORD_BITS-1:0] center_y,
  output logic [COORD_BITS-1:0] center_z,
  output logic [COORD_BITS-1:0] sphere_radius,
  output logic                  sphere_valid,
  output logic                  grew
);

  ibs_pkg::eng_stat_t    stat;
  logic                  out_free;
  logic [COORD_BITS-1:0] e_cx;
  logic [COORD_BITS-1:0] e_cy;
  logic [COORD_BITS-1:0] e_cz;
  logic [COORD_BITS-1:0] e_rad;
  logic                  e_has;
  logic                  e_grew;

  assign out_free    = !result_valid || result_ready;
  assign point_ready = stat.idle;

  ibs_engine #(.COORD_BITS(COORD_BITS)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (point_valid && point_ready),
    .kind       (kind),
    .px         (px),
    .py         (py),
    .pz         (pz),
    .out_free   (out_free),
    .stat       (stat),
    .cx         (e_cx),
    .cy         (e_cy),
    .cz         (e_cz),
    .rad        (e_rad),
    .has_sphere (e_has),
    .grew       (e_grew)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stat.done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      center_x      <= e_cx;
      center_y      <= e_cy;
      center_z      <= e_cz;
      sphere_radius <= e_rad;
      sphere_valid  <= e_has;
      grew          <= e_grew;
    end
  end

endmodule

/* test/tb_incremental_bounding_sphere_unit.sv */
`timescale 1ns / 100ps
module tb_incremental_bounding_sphere_unit;
  localparam int W = ibs_pkg::COORD_BITS_DEF;
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;
  localparam longint CMAX = 64'hFFFF_FFFF;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_LEN = 3000;

  typedef struct packed {
    logic kind;
    logic [W-1:0] x, y, z;
  } point_t;

  typedef struct packed {
    logic [W-1:0] cx, cy, cz, rad;
    logic valid, grew;
  } sphere_t;

  logic clk = 0;
  logic rst = 1;
  logic point_valid = 0;
  logic point_ready;
  logic kind = 0;
  logic [W-1:0] px = '0, py = '0, pz = '0;
  logic result_valid;
  logic result_ready = 0;
  logic [W-1:0] center_x, center_y, center_z, sphere_radius;
  logic sphere_valid, grew;

  incremental_bounding_sphere_unit uut (.*);

  always #4 clk = ~clk;

  point_t pending_points[$];
  sphere_t expected_spheres[$];
  longint sp_cx = 0, sp_cy = 0, sp_cz = 0;
  longint unsigned sp_rad = 0;
  bit sp_valid = 0;
  int errors = 0;
  int sent = 0, got = 0, grow_count = 0;
  longint cycles = 0;
  int send_idle_pct = 22, recv_idle_pct = 45;
  int hold_cycles = 0;
  int hold_reqs = 0, hold_seen = 0;
  bit send_pause = 0;

  function automatic longint unsigned isqrt128(logic [127:0] n);
    logic [127:0] res, b, t;
    res = 0;
    b = 128'd1 << 126;
    while (b != 0) begin
      t = res + b;
      if (n >= t) begin
        n = n - t;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[63:0];
  endfunction

  function automatic longint move_axis(longint c, longint d, longint unsigned dr,
                                       longint unsigned r);
    logic [127:0] m, q;
    m = 128'(d < 0 ? -d : d) * 128'(dr);
    q = m / 128'(r);
    return d < 0 ? c - longint'(q[63:0]) : c + longint'(q[63:0]);
  endfunction

  function automatic sphere_t grow_sphere(point_t p);
    sphere_t s;
    longint dx, dy, dz;
    longint unsigned r, dr;
    logic [127:0] sq;
    s.grew = 0;
    if (p.kind == KIND_CLEAR) begin
      sp_cx = 0; sp_cy = 0; sp_cz = 0; sp_rad = 0; sp_valid = 0;
    end else if (!sp_valid) begin
      sp_cx = longint'($signed(p.x));
      sp_cy = longint'($signed(p.y));
      sp_cz = longint'($signed(p.z));
      sp_rad = 0; sp_valid = 1; s.grew = 1;
    end else begin
      dx = longint'($signed(p.x)) - sp_cx;
      dy = longint'($signed(p.y)) - sp_cy;
      dz = longint'($signed(p.z)) - sp_cz;
      sq = 128'(dx < 0 ? -dx : dx) * 128'(dx < 0 ? -dx : dx)
         + 128'(dy < 0 ? -dy : dy) * 128'(dy < 0 ? -dy : dy)
         + 128'(dz < 0 ? -dz : dz) * 128'(dz < 0 ? -dz : dz);
      r = isqrt128(sq);
      if (r > sp_rad) begin
        dr = (r - sp_rad) >> 1;
        if (dr != 0) begin
          sp_cx = move_axis(sp_cx, dx, dr, r);
          sp_cy = move_axis(sp_cy, dy, dr, r);
          sp_cz = move_axis(sp_cz, dz, dr, r);
          sp_rad = (sp_rad + dr > CMAX) ? CMAX : sp_rad + dr;
          s.grew = 1;
        end
      end
    end
    s.cx = sp_cx[W-1:0]; s.cy = sp_cy[W-1:0]; s.cz = sp_cz[W-1:0];
    s.rad = sp_rad[W-1:0]; s.valid = sp_valid;
    return s;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("incremental_bounding_sphere_unit verification failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 0;
    end else begin
      if (point_valid && point_ready) begin
        expected_spheres.push_back(grow_sphere({kind, px, py, pz}));
        sent <= sent + 1;
      end
      if (!(point_valid && !point_ready)) begin
        if (pending_points.size() > 0 && !send_pause
            && $urandom_range(99) >= send_idle_pct) begin
          point_t p;
          p = pending_points.pop_front();
          point_valid <= 1;
          kind <= p.kind; px <= p.x; py <= p.y; pz <= p.z;
        end else begin
          point_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 0;
    end else begin
      if (result_valid && result_ready) begin
        sphere_t e;
        got <= got + 1;
        if (expected_spheres.size() == 0) begin
          $error("result with no transaction outstanding");
          errors++;
        end else begin
          e = expected_spheres.pop_front();
          if (grew) grow_count <= grow_count + 1;
          if (center_x !== e.cx) begin
            $error("center_x exp %h got %h", e.cx, center_x); errors++;
          end
          if (center_y !== e.cy) begin
            $error("center_y exp %h got %h", e.cy, center_y); errors++;
          end
          if (center_z !== e.cz) begin
            $error("center_z exp %h got %h", e.cz, center_z); errors++;
          end
          if (sphere_radius !== e.rad) begin
            $error("sphere_radius exp %h got %h", e.rad, sphere_radius); errors++;
          end
          if (sphere_valid !== e.valid) begin
            $error("sphere_valid exp %b got %b", e.valid, sphere_valid); errors++;
          end
          if (grew !== e.grew) begin
            $error("grew exp %b got %b", e.grew, grew); errors++;
          end
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_cycles <= HOLD_LEN;
        result_ready <= 0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        result_ready <= 0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic add_point(logic k, logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
    pending_points.push_back({k, x, y, z});
  endtask

  function automatic logic [W-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return W'($signed($urandom_range(65535 * 4)) - 131070);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(1000)
                                  : 32'h8000_0000 + $urandom_range(1000);
      default: return W'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_points.size() > 0 || point_valid || expected_spheres.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_block(int n);
    int mode;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(29) == 0) begin
        add_point(KIND_CLEAR, $urandom, $urandom, $urandom);
        mode = $urandom_range(3);
      end else begin
        mode = $urandom_range(3);
        add_point(KIND_POINT, rand_coord(mode), rand_coord(mode), rand_coord(mode));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    // first point, inside, on, just outside, and saturation
    add_point(KIND_POINT, 0, 0, 0);
    add_point(KIND_POINT, 0, 0, 0);
    add_point(KIND_POINT, 1, 0, 0);
    add_point(KIND_POINT, 3, 0, 0);
    add_point(KIND_POINT, 32'h0001_0000, 32'hFFFF_0000, 0);
    add_point(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_point(KIND_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(KIND_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(KIND_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_point(KIND_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_point(KIND_POINT, 0, 0, 0);
    add_point(KIND_CLEAR, 0, 0, 0);
    add_point(KIND_CLEAR, 0, 0, 0);
    add_point(KIND_POINT, 32'hFFFF_FFFF, 0, 32'h5555_5555);
    add_point(KIND_POINT, 32'hAAAA_AAAA, 32'h5555_5555, 0);
    add_point(KIND_POINT, 32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678);
    random_block(500);
    wait_drained();
    // long receiver stall while points keep coming
    hold_reqs++;
    random_block(30);
    wait_drained();
    send_idle_pct = 45; recv_idle_pct = 22;
    random_block(500);
    // sender pause mid-stream until all results return
    repeat (3000) @(posedge clk);
    send_pause = 1;
    @(posedge clk);
    while (point_valid || expected_spheres.size() > 0)
      @(posedge clk);
    send_pause = 0;
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_block(500);
    wait_drained();
    repeat (400) @(posedge clk);
    $display("covered %0d transactions, %0d results, %0d sphere growths",
             sent, got, grow_count);
    if (errors == 0 && expected_spheres.size() == 0) begin
      $display("incremental_bounding_sphere_unit verification clean");
    end else begin
      $display("incremental_bounding_sphere_unit verification failed");
    end
    $finish;
  end
endmodule
